// ===== hdl/glos_pkg.sv =====
package glos_pkg;

  // Coordinates of the map and of the query points are six bits wide.
  localparam int COORD_W = 6;

  // Width of the view range register.
  localparam int RANGE_W = 4;

  // Default side length of the square obstruction map.
  localparam int MAP_SIDE_DEF = 64;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [RANGE_W-1:0] range_t;

  localparam range_t VIEW_RANGE_RESET = range_t'(6);

endpackage

// ===== hdl/glos_in_if.sv =====
interface glos_in_if import glos_pkg::*; ();

  logic   valid;
  logic   ready;
  logic   kind;
  coord_t cell_x;
  coord_t cell_y;
  logic   cell_blocks;
  coord_t from_x;
  coord_t from_y;
  coord_t to_x;
  coord_t to_y;

  modport source (
    output valid, kind, cell_x, cell_y, cell_blocks, from_x, from_y, to_x, to_y,
    input  ready
  );

  modport sink (
    input  valid, kind, cell_x, cell_y, cell_blocks, from_x, from_y, to_x, to_y,
    output ready
  );

endinterface

// ===== hdl/glos_out_if.sv =====
interface glos_out_if import glos_pkg::*; ();

  logic valid;
  logic ready;
  logic visible;
  logic beyond_range;

  modport source (
    output valid, visible, beyond_range,
    input  ready
  );

  modport sink (
    input  valid, visible, beyond_range,
    output ready
  );

endinterface

// ===== hdl/glos_ram.sv =====
module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/grid_line_of_sight.sv =====
// Write transfers produce no result.
// A query within range whose major axis distance D is two or more walks the cells
// between its points, ending early when an obstructing cell is found.
// A query beyond range, or with D below two, is answered from set-up without a walk.
// A query holds the input until its result enters the output register, plus output stalls.
// After reset all MAP_SIDE*MAP_SIDE map cells are swept clear before in_ch.ready rises.
module grid_line_of_sight import glos_pkg::*; #(
  parameter int MAP_SIDE = MAP_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  glos_in_if.sink    in_ch,
  glos_out_if.source out_ch,
  input  logic       cfg_we,
  input  range_t     cfg_wdata
);

  // Map geometry. Cells are stored row by row at y*MAP_SIDE+x.
  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + COORD_W + 1;
  localparam logic [8:0]    SIDE_W    = 9'(MAP_SIDE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // The step accumulator holds 2*k*small + big reduced modulo 2*big.
  localparam int NUM_W = RANGE_W + 2;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  function automatic logic in_grid(coord_t x, coord_t y);
    return (9'(x) < SIDE_W) && (9'(y) < SIDE_W);
  endfunction

  function automatic logic [AW-1:0] cell_addr(coord_t x, coord_t y);
    logic [PW-1:0] lin;
    lin = PW'(y) * PW'(MAP_SIDE) + PW'(x);
    return lin[AW-1:0];
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  range_t           view_range_r;

  // Query points, captured on the input transfer.
  coord_t           fx_r, fy_r, tx_r, ty_r;

  // Walk set-up and walk state.
  logic             x_major_r, x_major_nxt;
  logic             maj_up_r, maj_up_nxt;
  logic             min_up_r, min_up_nxt;
  range_t           big_r, big_nxt;
  range_t           small_r, small_nxt;
  coord_t           maj_r, maj_nxt;
  coord_t           mnr_r, mnr_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  range_t           count_r, count_nxt;
  logic             pending_r, pending_nxt;
  logic             ingrid_r, ingrid_nxt;

  // Finished answer and the output register.
  logic             res_visible_r, res_visible_nxt;
  logic             res_beyond_r, res_beyond_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_visible_r, out_beyond_r;

  // Map port.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic             ram_rdata;

  logic             in_xfer, out_load;

  // Set-up arithmetic on the captured points.
  coord_t           adx, ady, big_c, small_c, maj0, maj1, min0, min1;
  logic             xm_c, beyond_c;

  // Shared step unit: one add, one compare and subtract against 2*big, one step of each coordinate.
  logic [NUM_W-1:0] step_sum, two_big;
  logic             step_carry;
  logic [NUM_W-1:0] step_num;
  coord_t           step_maj, step_mnr, step_x, step_y;
  logic             blocked;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.visible      = out_visible_r;
  assign out_ch.beyond_range = out_beyond_r;

  // The answer leaves the sequencer once the output register is free or being emptied.
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  always_comb begin
    adx      = (fx_r > tx_r) ? fx_r - tx_r : tx_r - fx_r;
    ady      = (fy_r > ty_r) ? fy_r - ty_r : ty_r - fy_r;
    beyond_c = (adx > COORD_W'(view_range_r)) || (ady > COORD_W'(view_range_r));
    xm_c     = (adx >= ady);
    big_c    = xm_c ? adx : ady;
    small_c  = xm_c ? ady : adx;
    maj0     = xm_c ? fx_r : fy_r;
    maj1     = xm_c ? tx_r : ty_r;
    min0     = xm_c ? fy_r : fx_r;
    min1     = xm_c ? ty_r : tx_r;
  end

  // Each step moves one cell along the major axis. The minor coordinate moves by one
  // whenever the accumulator passes 2*big, which tracks round-half-away of k*small/big.
  always_comb begin
    two_big    = NUM_W'({big_r, 1'b0});
    step_sum   = num_r + NUM_W'({small_r, 1'b0});
    step_carry = (step_sum >= two_big);
    step_num   = step_carry ? step_sum - two_big : step_sum;
    step_maj   = maj_up_r ? maj_r + coord_t'(1) : maj_r - coord_t'(1);
    if (!step_carry) begin
      step_mnr = mnr_r;
    end else if (min_up_r) begin
      step_mnr = mnr_r + coord_t'(1);
    end else begin
      step_mnr = mnr_r - coord_t'(1);
    end
    step_x = x_major_r ? step_maj : step_mnr;
    step_y = x_major_r ? step_mnr : step_maj;
  end

  assign ram_raddr = cell_addr(step_x, step_y);

  // A cell outside the map never obstructs; the read of such a cell is simply ignored.
  assign blocked = pending_r && ingrid_r && ram_rdata;

  // Map writes come from the clearing sweep or from a write transfer inside the grid.
  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = in_xfer && !in_ch.kind && in_grid(in_ch.cell_x, in_ch.cell_y);
      ram_waddr = cell_addr(in_ch.cell_x, in_ch.cell_y);
      ram_wdata = in_ch.cell_blocks;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    x_major_nxt     = x_major_r;
    maj_up_nxt      = maj_up_r;
    min_up_nxt      = min_up_r;
    big_nxt         = big_r;
    small_nxt       = small_r;
    maj_nxt         = maj_r;
    mnr_nxt         = mnr_r;
    num_nxt         = num_r;
    count_nxt       = count_r;
    pending_nxt     = pending_r;
    ingrid_nxt      = ingrid_r;
    res_visible_nxt = res_visible_r;
    res_beyond_nxt  = res_beyond_r;

    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_xfer && in_ch.kind) begin
          state_nxt = S_SETUP;
        end
      end

      S_SETUP: begin
        x_major_nxt = xm_c;
        maj_up_nxt  = (maj1 >= maj0);
        min_up_nxt  = (min1 >= min0);
        big_nxt     = big_c[RANGE_W-1:0];
        small_nxt   = small_c[RANGE_W-1:0];
        maj_nxt     = maj0;
        mnr_nxt     = min0;
        num_nxt     = NUM_W'(big_c[RANGE_W-1:0]);
        count_nxt   = big_c[RANGE_W-1:0] - range_t'(1);
        pending_nxt = 1'b0;
        if (beyond_c) begin
          res_visible_nxt = 1'b0;
          res_beyond_nxt  = 1'b1;
          state_nxt       = S_FINISH;
        end else if (big_c <= coord_t'(1)) begin
          // Equal or adjacent points: nothing lies between them.
          res_visible_nxt = 1'b1;
          res_beyond_nxt  = 1'b0;
          state_nxt       = S_FINISH;
        end else begin
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        // The read issued last cycle is checked while the next one is issued.
        if (blocked) begin
          res_visible_nxt = 1'b0;
          res_beyond_nxt  = 1'b0;
          pending_nxt     = 1'b0;
          state_nxt       = S_FINISH;
        end else if (count_r == range_t'(0)) begin
          res_visible_nxt = 1'b1;
          res_beyond_nxt  = 1'b0;
          pending_nxt     = 1'b0;
          state_nxt       = S_FINISH;
        end else begin
          maj_nxt     = step_maj;
          mnr_nxt     = step_mnr;
          num_nxt     = step_num;
          count_nxt   = count_r - range_t'(1);
          pending_nxt = 1'b1;
          ingrid_nxt  = in_grid(step_x, step_y);
        end
      end

      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      view_range_r <= VIEW_RANGE_RESET;
      pending_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        view_range_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fx_r <= in_ch.from_x;
      fy_r <= in_ch.from_y;
      tx_r <= in_ch.to_x;
      ty_r <= in_ch.to_y;
    end
    x_major_r     <= x_major_nxt;
    maj_up_r      <= maj_up_nxt;
    min_up_r      <= min_up_nxt;
    big_r         <= big_nxt;
    small_r       <= small_nxt;
    maj_r         <= maj_nxt;
    mnr_r         <= mnr_nxt;
    num_r         <= num_nxt;
    count_r       <= count_nxt;
    ingrid_r      <= ingrid_nxt;
    res_visible_r <= res_visible_nxt;
    res_beyond_r  <= res_beyond_nxt;
    if (out_load) begin
      out_visible_r <= res_visible_r;
      out_beyond_r  <= res_beyond_r;
    end
  end

  glos_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // A query out of range is never reported as visible.
  a_beyond_not_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.visible && out_ch.beyond_range))
    else $error("beyond-range result flagged visible");

  // The step accumulator stays reduced below twice the major distance.
  a_num_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (num_r < NUM_W'({big_r, 1'b0})))
    else $error("walk accumulator out of range");

  // An accepted query always proceeds to set-up on the next cycle.
  a_query_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.kind) |=> (state_r == S_SETUP))
    else $error("query transfer did not start set-up");

  // A new result appears only from the finishing state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FINISH))
    else $error("result raised outside the finishing state");

  // No map write from the input side can occur during the clearing sweep.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready)
    else $error("input ready during the clearing sweep");

endmodule
